/* rtl/hebbian_edge_weight_table_macros.svh */
// Assertion macros for the edge weight table
`ifndef HEBBIAN_EDGE_WEIGHT_TABLE_MACROS_SVH
`define HEBBIAN_EDGE_WEIGHT_TABLE_MACROS_SVH
`define HEWT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hewt check failed");
`define HEWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hewt check failed");
`endif

/* rtl/hewt_pkg.sv */
// Package: types, constants and helpers for the edge weight table
`timescale 1ns / 1ps
`default_nettype none
package hewt_pkg;
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_EDGES_DEF  = 256;
  localparam int NAME_BYTES_DEF = 8;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_FIND  = 3'd1;
  localparam logic [2:0] KIND_CONN  = 3'd2;
  localparam logic [2:0] KIND_LEARN = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADID    = 2'd3;

  localparam logic [1:0] REG_INIT = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_WMAX = 2'd2;
  localparam logic [1:0] REG_WMIN = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] node_name;
    logic [7:0]  node_type;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic        passed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  node_id;
    logic [31:0] hits;
    logic [7:0]  edge_weight;
    logic [15:0] pass_count;
    logic [15:0] fail_count;
    logic [31:0] learn_total;
  } out_item_t;

  // edge record: source, target, weight, passes, fails
  typedef struct packed {
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [7:0]  weight;
    logic [15:0] passes;
    logic [15:0] fails;
  } edge_rec_t;

  // keep the low bytes up to the first zero byte, and at most nbytes of them
  function automatic logic [63:0] norm_key(input logic [63:0] k, input int nbytes);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] learn_weight(input logic [7:0] cw, input logic pass,
                                              input logic [7:0] step, input logic [7:0] wmax,
                                              input logic [7:0] wmin);
    logic [8:0] up;
    logic [8:0] floor_v;
    up      = {1'b0, cw} + {1'b0, step};
    floor_v = {1'b0, wmin} + {1'b0, step};
    if (pass) return (up > {1'b0, wmax}) ? wmax : up[7:0];
    return ({1'b0, cw} < floor_v) ? wmin : (cw - step);
  endfunction
endpackage
`default_nettype wire

/* rtl/hebbian_edge_weight_table.sv */
// Top level: node and edge tables with a command sequencer
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | in_item_t
//  out     | output    | out_valid/out_stall | out_item_t
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
// Steps per command: add/find scan the node table; read scans the edge table;
// connect scans twice (a->b, b->a) with a write gap, then updates both hit counts;
// learn reads each edge and writes back those on node_a; clear and rejects go to done.
// Reset restores the config defaults and clears the totals and counters; no clearing pass over the memories.
// A new beat is taken while the last result waits; a finished command holds
// in its final state while the output register is stalled.
`timescale 1ns / 1ps
`default_nettype none
module hebbian_edge_weight_table
  import hewt_pkg::*;
#(
  parameter int MAX_EDGES  = MAX_EDGES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
`include "hebbian_edge_weight_table_macros.svh"
  localparam int MAX_NODES = MAX_NODES_DEF;
  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int IW = (EW > NW) ? EW : NW;
  localparam int NODE_W = 64 + 8 + 32;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NSCAN = 4'd1;
  localparam logic [3:0] S_ESCAN = 4'd2;
  localparam logic [3:0] S_EADD  = 4'd3;
  localparam logic [3:0] S_HITA  = 4'd4;
  localparam logic [3:0] S_HITAW = 4'd5;
  localparam logic [3:0] S_HITB  = 4'd6;
  localparam logic [3:0] S_HITBW = 4'd7;
  localparam logic [3:0] S_LRN   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [7:0] init_weight, learn_step, weight_max, weight_min;
  always_ff @(posedge clk) begin
    if (rst) begin
      init_weight <= 8'd128;
      learn_step  <= 8'd5;
      weight_max  <= 8'd255;
      weight_min  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT: init_weight <= cfg_data;
        REG_STEP: learn_step  <= cfg_data;
        REG_WMAX: weight_max  <= cfg_data;
        REG_WMIN: weight_min  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]   state;
  in_item_t     cmd;
  logic [63:0]  key;
  logic [NW:0]  node_total;
  logic [EW:0]  edge_total;
  logic [31:0]  learn_counter;
  logic [IW:0]  idx;       // scan position (also counts issued reads)
  logic         rd_vld;    // a read was issued last cycle
  logic [IW:0]  rd_idx;
  logic         phase;     // connect: 0 = a->b, 1 = b->a
  logic         found;
  out_item_t    res;
  out_item_t    res_out;

  // node memory
  logic              n_we;
  logic [NW-1:0]     n_waddr, n_raddr;
  logic [NODE_W-1:0] n_wdata, n_rdata;
  hewt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata));

  // edge memory
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  edge_rec_t     e_wdata, e_rdata;
  hewt_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));

  logic [63:0] n_key;
  logic [31:0] n_hits;
  assign n_key  = n_rdata[NODE_W-1 -: 64];
  assign n_hits = n_rdata[31:0];

  logic [5:0] es, ed;
  assign es = phase ? cmd.node_b : cmd.node_a;
  assign ed = phase ? cmd.node_a : cmd.node_b;

  logic scan_more;
  assign scan_more = (state == S_NSCAN) ? (32'(idx) < 32'(node_total))
                                        : (32'(idx) < 32'(edge_total));

  assign in_stall = (state != S_IDLE);

  always_comb begin
    res_out             = res;
    res_out.learn_total = learn_counter;
  end

  always_comb begin
    n_raddr = idx[NW-1:0];
    e_raddr = idx[EW-1:0];
    if (state == S_HITA) n_raddr = cmd.node_a[NW-1:0];
    if (state == S_HITB) n_raddr = cmd.node_b[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      node_total    <= '0;
      edge_total    <= '0;
      learn_counter <= '0;
      rd_vld        <= 1'b0;
      n_we          <= 1'b0;
      e_we          <= 1'b0;
      res           <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd    <= in_item;
            key    <= norm_key(in_item.node_name, NAME_BYTES);
            idx    <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            phase  <= 1'b0;
            case (in_item.kind)
              KIND_ADD, KIND_FIND: state <= S_NSCAN;
              KIND_CONN: begin
                if ({1'b0, in_item.node_a} >= node_total ||
                    {1'b0, in_item.node_b} >= node_total) begin
                  res.status <= ST_BADID;
                  state      <= S_DONE;
                end else state <= S_ESCAN;
              end
              KIND_LEARN: begin
                if ({1'b0, in_item.node_a} >= node_total) begin
                  res.status <= ST_BADID;
                  state      <= S_DONE;
                end else state <= S_LRN;
              end
              KIND_READ: state <= S_ESCAN;
              KIND_CLEAR: begin
                node_total    <= '0;
                edge_total    <= '0;
                learn_counter <= '0;
                state         <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_NSCAN: begin
          // issue read at idx, compare the one read last cycle
          rd_vld <= scan_more;
          rd_idx <= idx;
          if (scan_more) idx <= idx + 1'b1;
          if (rd_vld && n_key == key) begin
            res.node_id <= 6'(rd_idx);
            res.hits    <= n_hits;
            state       <= S_DONE;
          end else if (!rd_vld && idx != '0) begin
            if (cmd.kind == KIND_FIND) res.status <= ST_NOTFOUND;
            else if (node_total >= (NW+1)'(MAX_NODES)) res.status <= ST_FULL;
            else begin
              n_we        <= 1'b1;
              n_waddr     <= node_total[NW-1:0];
              n_wdata     <= {key, cmd.node_type, 32'd0};
              res.node_id <= 6'(node_total);
              node_total  <= node_total + 1'b1;
            end
            state <= S_DONE;
          end else if (!rd_vld && !scan_more) begin
            // empty table
            idx <= idx + 1'b1;
          end
        end
        S_ESCAN: begin
          // hold off reading while a new edge is still being written
          e_we   <= 1'b0;
          rd_vld <= scan_more && !e_we;
          rd_idx <= idx;
          if (scan_more && !e_we) idx <= idx + 1'b1;
          if (rd_vld && e_rdata.src == es && e_rdata.dst == ed) begin
            if (cmd.kind == KIND_READ) begin
              res.edge_weight <= e_rdata.weight;
              res.pass_count  <= e_rdata.passes;
              res.fail_count  <= e_rdata.fails;
              state           <= S_DONE;
            end else begin
              found <= 1'b1;
              state <= S_EADD;
            end
          end else if (!rd_vld && !scan_more) begin
            if (cmd.kind == KIND_READ) begin
              res.status <= ST_NOTFOUND;
              state      <= S_DONE;
            end else state <= S_EADD;
          end
        end
        S_EADD: begin
          if (!found && edge_total < (EW+1)'(MAX_EDGES)) begin
            e_we       <= 1'b1;
            e_waddr    <= edge_total[EW-1:0];
            e_wdata    <= '{src: es, dst: ed, weight: init_weight, passes: 16'd0,
                            fails: 16'd0};
            edge_total <= edge_total + 1'b1;
          end
          found  <= 1'b0;
          idx    <= '0;
          rd_vld <= 1'b0;
          if (!phase) begin
            phase <= 1'b1;
            state <= S_ESCAN;
          end else state <= S_HITA;
        end
        S_HITA: begin
          e_we  <= 1'b0;
          state <= S_HITAW;
        end
        S_HITAW: begin
          n_we    <= 1'b1;
          n_waddr <= cmd.node_a[NW-1:0];
          n_wdata <= {n_rdata[NODE_W-1:32], n_hits + 32'd1};
          state   <= S_HITB;
        end
        S_HITB: begin
          n_we  <= 1'b0;
          state <= S_HITBW;
        end
        S_HITBW: begin
          // a self connect reads the entry while it is being written: take the new word
          n_we    <= 1'b1;
          n_waddr <= cmd.node_b[NW-1:0];
          if (cmd.node_a == cmd.node_b)
            n_wdata <= {n_wdata[NODE_W-1:32], n_wdata[31:0] + 32'd1};
          else
            n_wdata <= {n_rdata[NODE_W-1:32], n_hits + 32'd1};
          state   <= S_DONE;
        end
        S_LRN: begin
          // read one edge, write it back the next cycle if it touches node_a; alternate to avoid overlap
          if (rd_vld) begin
            rd_vld <= 1'b0;
            if (e_rdata.src == cmd.node_a || e_rdata.dst == cmd.node_a) begin
              e_we    <= 1'b1;
              e_waddr <= rd_idx[EW-1:0];
              e_wdata <= '{src: e_rdata.src, dst: e_rdata.dst,
                           weight: learn_weight(e_rdata.weight, cmd.passed, learn_step,
                                                weight_max, weight_min),
                           passes: e_rdata.passes + {15'd0, cmd.passed},
                           fails:  e_rdata.fails + {15'd0, !cmd.passed}};
            end
          end else if (scan_more) begin
            e_we   <= 1'b0;
            rd_vld <= 1'b1;
            rd_idx <= idx;
            idx    <= idx + 1'b1;
          end else begin
            e_we          <= 1'b0;
            learn_counter <= learn_counter + 32'd1;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          n_we <= 1'b0;
          e_we <= 1'b0;
          // hold while the previous result is still stalled
          if (!out_valid || !out_stall) begin
            out_item  <= res_out;
            out_valid <= 1'b1;
            res       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HEWT_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `HEWT_ASSERT_IMPL(a_node_bound, clk, rst, 1'b1, node_total <= (NW+1)'(MAX_NODES))
  `HEWT_ASSERT_IMPL(a_edge_bound, clk, rst, 1'b1, edge_total <= (EW+1)'(MAX_EDGES))
  `HEWT_ASSERT_NEXT(a_done_out, clk, rst, state == S_DONE && !(out_valid && out_stall), out_valid && state == S_IDLE)
endmodule
`default_nettype wire

/* rtl/hewt_ram.sv */
// Generic single-port write, single read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module hewt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* bench/tb_hebbian_edge_weight_table.sv */
// Testbench for the edge weight table: directed and random commands, self-checked
`timescale 1ns / 1ps
module tb_hebbian_edge_weight_table;
  import hewt_pkg::*;

  localparam int NODE_CAP = 64;
  localparam int EDGE_CAP = 256;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_INIT;
  logic [7:0] cfg_data = '0;

  hebbian_edge_weight_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the block's tables
  logic [63:0] m_keys [NODE_CAP];
  logic [31:0] m_hits [NODE_CAP];
  int unsigned m_nodes;
  logic [5:0]  m_src [EDGE_CAP];
  logic [5:0]  m_dst [EDGE_CAP];
  logic [7:0]  m_wt [EDGE_CAP];
  logic [15:0] m_pass [EDGE_CAP];
  logic [15:0] m_fail [EDGE_CAP];
  int unsigned m_edges;
  logic [31:0] m_learns;
  logic [7:0]  r_init = 8'd128, r_step = 8'd5, r_wmax = 8'd255, r_wmin = 8'd0;

  out_item_t expected_q[$];
  int errors = 0;
  int beats_in = 0, beats_out = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;
  bit out_quiet = 1'b0;
  int kind_seen[8];

  function automatic logic [63:0] trim_name(logic [63:0] k);
    logic [63:0] r;
    bit stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int find_node(logic [63:0] key);
    for (int i = 0; i < m_nodes; i++) if (m_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic int edge_slot(logic [5:0] s, logic [5:0] d);
    for (int i = 0; i < m_edges; i++) if (m_src[i] == s && m_dst[i] == d) return i;
    return -1;
  endfunction

  function automatic void add_edge(logic [5:0] s, logic [5:0] d);
    if (edge_slot(s, d) < 0 && m_edges < EDGE_CAP) begin
      m_src[m_edges] = s;
      m_dst[m_edges] = d;
      m_wt[m_edges] = r_init;
      m_pass[m_edges] = '0;
      m_fail[m_edges] = '0;
      m_edges++;
    end
  endfunction

  function automatic out_item_t table_response(in_item_t c);
    out_item_t r;
    logic [63:0] key;
    int n;
    logic [8:0] up;
    r = '0;
    key = trim_name(c.node_name);
    case (c.kind)
      KIND_ADD, KIND_FIND: begin
        n = find_node(key);
        if (n >= 0) begin
          r.node_id = n[5:0];
          r.hits = m_hits[n];
        end else if (c.kind == KIND_FIND) begin
          r.status = ST_NOTFOUND;
        end else if (m_nodes >= NODE_CAP) begin
          r.status = ST_FULL;
        end else begin
          m_keys[m_nodes] = key;
          m_hits[m_nodes] = '0;
          r.node_id = m_nodes[5:0];
          m_nodes++;
        end
      end
      KIND_CONN: begin
        if (c.node_a >= m_nodes || c.node_b >= m_nodes) begin
          r.status = ST_BADID;
        end else begin
          add_edge(c.node_a, c.node_b);
          add_edge(c.node_b, c.node_a);
          m_hits[c.node_a] += 1;
          m_hits[c.node_b] += 1;
        end
      end
      KIND_LEARN: begin
        if (c.node_a >= m_nodes) begin
          r.status = ST_BADID;
        end else begin
          for (int i = 0; i < m_edges; i++) begin
            if (m_src[i] == c.node_a || m_dst[i] == c.node_a) begin
              if (c.passed) begin
                m_pass[i] += 1;
                up = {1'b0, m_wt[i]} + {1'b0, r_step};
                m_wt[i] = (up > {1'b0, r_wmax}) ? r_wmax : up[7:0];
              end else begin
                m_fail[i] += 1;
                if ({1'b0, m_wt[i]} < {1'b0, r_wmin} + {1'b0, r_step}) m_wt[i] = r_wmin;
                else m_wt[i] = m_wt[i] - r_step;
              end
            end
          end
          m_learns += 1;
        end
      end
      KIND_READ: begin
        n = edge_slot(c.node_a, c.node_b);
        if (n < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.edge_weight = m_wt[n];
          r.pass_count = m_pass[n];
          r.fail_count = m_fail[n];
        end
      end
      KIND_CLEAR: begin
        m_nodes = 0;
        m_edges = 0;
        m_learns = '0;
      end
      default: ;
    endcase
    r.learn_total = m_learns;
    return r;
  endfunction

  // valid stays up after a beat until the next one is driven or the sender idles
  task automatic send_cmd(in_item_t c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(table_response(c));
    kind_seen[c.kind]++;
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4 * EDGE_CAP + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT: r_init = v;
      REG_STEP: r_step = v;
      REG_WMAX: r_wmax = v;
      default:  r_wmin = v;
    endcase
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [2:0] k, logic [63:0] nm, logic [5:0] a,
                                  logic [5:0] b, logic p);
    in_item_t c;
    c.kind = k;
    c.node_name = nm;
    c.node_type = 8'($urandom);
    c.node_a = a;
    c.node_b = b;
    c.passed = p;
    return c;
  endfunction

  // names drawn half the time from a small pool so that adds and finds hit known keys
  function automatic logic [63:0] pool_name();
    logic [63:0] nm;
    nm = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: nm = 64'(8'($urandom_range(1, 40)));
      1: nm = {nm[63:16], 8'h00, 8'($urandom_range(1, 40))};
      default: ;
    endcase
    return nm;
  endfunction

  function automatic logic [5:0] pick_id();
    if (m_nodes != 0 && $urandom_range(0, 9) != 0) return 6'($urandom_range(0, m_nodes - 1));
    return 6'($urandom);
  endfunction

  task automatic test_directed();
    send_cmd(mk(KIND_FIND, 64'h41, 0, 0, 0));
    send_cmd(mk(KIND_CONN, 0, 0, 0, 0));
    send_cmd(mk(KIND_LEARN, 0, 0, 0, 1));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 64'h0000_0000_0000_0001, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 64'hFFFF_FFFF_FF00_0001, 0, 0, 0));  // same key after the zero byte
    send_cmd(mk(KIND_ADD, 64'h0000_0000_0000_0000, 0, 0, 0));
    send_cmd(mk(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    send_cmd(mk(KIND_CONN, 0, 0, 1, 0));
    send_cmd(mk(KIND_CONN, 0, 2, 2, 0));  // self edge
    send_cmd(mk(KIND_CONN, 0, 3, 0, 0));
    send_cmd(mk(KIND_CONN, 0, 0, 63, 0));
    send_cmd(mk(KIND_LEARN, 0, 0, 0, 1));
    send_cmd(mk(KIND_LEARN, 0, 2, 0, 0));
    send_cmd(mk(KIND_LEARN, 0, 63, 0, 1));
    send_cmd(mk(KIND_READ, 0, 0, 1, 0));
    send_cmd(mk(KIND_READ, 0, 1, 0, 0));
    send_cmd(mk(KIND_READ, 0, 2, 2, 0));
    send_cmd(mk(KIND_READ, 0, 1, 2, 0));
    send_cmd(mk(6, 64'h55, 0, 0, 1));
    send_cmd(mk(7, 64'hAA, 63, 63, 0));
    send_cmd(mk(KIND_FIND, 64'h0000_0000_0000_0001, 0, 0, 0));
    send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0));
    send_cmd(mk(KIND_FIND, 64'h0000_0000_0000_0001, 0, 0, 0));
  endtask

  // fill the node table past capacity, connect node pairs, then learn and read back
  task automatic test_capacity();
    for (int i = 0; i < NODE_CAP + 2; i++) send_cmd(mk(KIND_ADD, 64'(i + 1), 0, 0, 0));
    for (int i = 0; i < 140; i++) send_cmd(mk(KIND_CONN, 0, 6'(i), 6'((i * 7 + 3) % 64), 0));
    for (int i = 0; i < 6; i++) send_cmd(mk(KIND_LEARN, 0, 6'(i), 0, i[0]));
    send_cmd(mk(KIND_READ, 0, 0, 3, 0));
    send_cmd(mk(KIND_READ, 0, 63, 56, 0));
  endtask

  task automatic test_random(int count, int conn_bias);
    in_item_t c;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 18)                  c = mk(KIND_ADD, pool_name(), 0, 0, 0);
      else if (k < 28)             c = mk(KIND_FIND, pool_name(), 0, 0, 0);
      else if (k < 28 + conn_bias) c = mk(KIND_CONN, 0, pick_id(), pick_id(), 0);
      else if (k < 70)             c = mk(KIND_LEARN, 0, pick_id(), 0, 1'($urandom));
      else if (k < 97)             c = mk(KIND_READ, 0, pick_id(), pick_id(), 0);
      else if (k < 98)             c = mk(KIND_CLEAR, 0, 0, 0, 0);
      else                         c = mk(3'($urandom_range(6, 7)), {$urandom, $urandom},
                                          6'($urandom), 6'($urandom), 1'($urandom));
      c.node_type = 8'($urandom);
      send_cmd(c);
    end
  endtask

  task automatic test_registers();
    logic [7:0] s [4][4];
    s = '{'{8'd0, 8'd255, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd255, 8'd0},
          '{8'd200, 8'd40, 8'd180, 8'd60}, '{8'd10, 8'd0, 8'd100, 8'd120}};
    for (int p = 0; p < 4; p++) begin
      drain();
      for (int r = 0; r < 4; r++) write_reg(2'(r), s[p][r]);
      send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0));
      test_random(60, 20);
    end
    drain();
    for (int r = 0; r < 4; r++) write_reg(2'(r), 8'($urandom));
    test_random(100, 15);
  endtask

  // output stall bursts
  always @(posedge clk) begin
    if (out_quiet) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(0, 4) != 0);
    else out_stall <= ($urandom_range(0, 5) == 0);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, out_item);
      end else begin
        e = expected_q.pop_front();
        if (out_item.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_item.status);
        if (out_item.node_id !== e.node_id)
          $display("%0t: node_id exp %0d got %0d", $time, e.node_id, out_item.node_id);
        if (out_item.hits !== e.hits)
          $display("%0t: hits exp %0d got %0d", $time, e.hits, out_item.hits);
        if (out_item.edge_weight !== e.edge_weight)
          $display("%0t: edge_weight exp %0d got %0d", $time, e.edge_weight,
                   out_item.edge_weight);
        if (out_item.pass_count !== e.pass_count)
          $display("%0t: pass_count exp %0d got %0d", $time, e.pass_count, out_item.pass_count);
        if (out_item.fail_count !== e.fail_count)
          $display("%0t: fail_count exp %0d got %0d", $time, e.fail_count, out_item.fail_count);
        if (out_item.learn_total !== e.learn_total)
          $display("%0t: learn_total exp %0d got %0d", $time, e.learn_total,
                   out_item.learn_total);
        if (out_item !== e) errors++;
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("hebbian_edge_weight_table verification failed");
      $finish;
    end
  end

  initial begin
    m_nodes = 0;
    m_edges = 0;
    m_learns = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    drain();  // hold the sender until everything is back
    test_registers();
    send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0));
    test_random(460, 25);
    quiet = 1'b1;
    out_quiet = 1'b1;
    test_random(120, 25);
    drain();
    $display("Sent %0d commands, checked %0d results (add %0d, find %0d, connect %0d,",
             beats_in, beats_out, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("learn %0d, read %0d, clear %0d, unused %0d), five register settings.",
             kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6] + kind_seen[7]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("hebbian_edge_weight_table verification clean");
    end else begin
      $display("hebbian_edge_weight_table verification failed");
    end
    $finish;
  end
endmodule
